// File: rtl/tlg_pkg.sv
// Shared types, widths and constants of the track likelihood gate.
package tlg_pkg;

    localparam int IN_W    = 160;   // packed input request, whole bytes
    localparam int OUT_W   = 40;    // packed result, whole bytes
    localparam int LIK_W   = 17;
    localparam int PRED_W  = 18;
    localparam int VAR_W   = 24;
    localparam int DET_W   = 48;
    localparam int REM_W   = 69;    // remainder after the range check
    localparam int QV_W    = 21;
    localparam int N_TERMS = 12;
    localparam int N_SQ    = 4;

    localparam logic [QV_W-1:0]  Q_CAP = 21'd1572864;   // q/2 = 12
    localparam logic [VAR_W-1:0] RST_MIN_POS   = 24'd5898;
    localparam logic [VAR_W-1:0] RST_MIN_DIR   = 24'd655;
    localparam logic [VAR_W-1:0] RST_MIN_CROSS = 24'd655;
    localparam logic [LIK_W-1:0] RST_THRESHOLD = 17'd6554;
    localparam logic [LIK_W-1:0] LIK_ONE       = 17'd65536;

    typedef enum logic [1:0] {
        REG_MIN_POS   = 2'd0,
        REG_MIN_DIR   = 2'd1,
        REG_MIN_CROSS = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_reg;

    typedef struct packed {
        logic                     zero;   // likelihood forced to 0
        logic                     sing;
        logic signed [PRED_W-1:0] pred;
    } t_meta;

    // floor(2^32 / k); k of one saturates, the correction step restores it
    function automatic logic [31:0] recip(input int k);
        logic [31:0] m;
        case (k)
            2:       m = 32'h8000_0000;
            3:       m = 32'h5555_5555;
            4:       m = 32'h4000_0000;
            5:       m = 32'h3333_3333;
            6:       m = 32'h2AAA_AAAA;
            7:       m = 32'h2492_4924;
            8:       m = 32'h2000_0000;
            9:       m = 32'h1C71_C71C;
            10:      m = 32'h1999_9999;
            11:      m = 32'h1745_D174;
            12:      m = 32'h1555_5555;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/track_likelihood_gate.sv
// Top level: pipelined Mahalanobis gate with exponential likelihood.
// Takes one track request per cycle unless the output side stalls, and returns one
// result per request, in order. A request passes the 21-stage restoring divider that
// forms q, the 36-stage Taylor series of the exponential (three stages per term:
// product, reciprocal multiply, correction) and then four squaring stages. A stall on
// the output freezes the whole pipeline; nothing is dropped or repeated. Configuration
// registers are read when a request enters (clamps) and leaves (threshold), so write
// them only while the pipeline is empty.
module track_likelihood_gate
    import tlg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // entry_pos, entry_dir, exit_pos, exit_dir, separation, var_pos_raw,
    // var_cross_raw, var_dir_raw (low to high)
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // likelihood, predicted_pos, excluded, singular (low to high)
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic w_adv;

    // ---------------- configuration ----------------
    logic [VAR_W-1:0] r_min_pos, r_min_dir, r_min_cross;
    logic [LIK_W-1:0] r_thr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pos   <= RST_MIN_POS;
            r_min_dir   <= RST_MIN_DIR;
            r_min_cross <= RST_MIN_CROSS;
            r_thr       <= RST_THRESHOLD;
        end else if (psel && penable && pwrite) begin
            case (t_reg'(paddr[3:2]))
                REG_MIN_POS:   r_min_pos   <= pwdata[VAR_W-1:0];
                REG_MIN_DIR:   r_min_dir   <= pwdata[VAR_W-1:0];
                REG_MIN_CROSS: r_min_cross <= pwdata[VAR_W-1:0];
                REG_THRESHOLD: r_thr       <= pwdata[LIK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_MIN_POS:   prdata = 32'(r_min_pos);
            REG_MIN_DIR:   prdata = 32'(r_min_dir);
            REG_MIN_CROSS: prdata = 32'(r_min_cross);
            REG_THRESHOLD: prdata = 32'(r_thr);
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- input fields ----------------
    logic signed [15:0] w_ep, w_ed, w_xp, w_xd;
    logic signed [16:0] w_sep;
    logic [VAR_W-1:0]   w_pv, w_dv;
    logic signed [24:0] w_xc;

    assign w_ep  = i_s_tdata[15:0];
    assign w_ed  = i_s_tdata[31:16];
    assign w_xp  = i_s_tdata[47:32];
    assign w_xd  = i_s_tdata[63:48];
    assign w_sep = i_s_tdata[80:64];
    assign w_pv  = i_s_tdata[104:81];
    assign w_xc  = i_s_tdata[129:105];
    assign w_dv  = i_s_tdata[153:130];

    assign o_s_tready = w_adv;

    // ---------------- stage 1: clamps, slope product ----------------
    logic               r1_v;
    logic signed [15:0] r1_ep, r1_xp;
    logic signed [32:0] r1_sd;
    logic signed [16:0] r1_b;
    logic [VAR_W-1:0]   r1_p, r1_d, r1_x;
    logic signed [32:0] w_sd;
    logic               w_xlow;

    assign w_sd   = w_sep * w_ed;
    assign w_xlow = w_xc < $signed({2'b00, r_min_cross});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r1_v <= 1'b0;
        else if (w_adv) r1_v <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ep <= w_ep;
            r1_xp <= w_xp;
            r1_sd <= w_sd;
            r1_b  <= 17'(w_xd) - 17'(w_ed);
            r1_p  <= (w_pv < r_min_pos) ? r_min_pos : w_pv;
            r1_d  <= (w_dv < r_min_dir) ? r_min_dir : w_dv;
            r1_x  <= w_xlow ? r_min_cross : w_xc[VAR_W-1:0];
        end
    end

    // ---------------- stage 2: prediction, determinant products ----------------
    logic                     r2_v;
    logic signed [15:0]       r2_xp;
    logic signed [16:0]       r2_b;
    logic [VAR_W-1:0]         r2_p, r2_d, r2_x;
    logic [DET_W-1:0]         r2_pd, r2_xx;
    logic signed [PRED_W-1:0] r2_pred;
    logic signed [32:0]       w_rs;
    logic signed [17:0]       w_step;
    logic signed [19:0]       w_psum;
    logic signed [PRED_W-1:0] w_pred;

    assign w_rs   = r1_sd + 33'sd16384;
    assign w_step = w_rs[32:15];
    assign w_psum = 20'(r1_ep) + 20'(w_step);

    always_comb begin
        if (w_psum > 20'sd131071)       w_pred = 18'sd131071;
        else if (w_psum < -20'sd131072) w_pred = -18'sd131072;
        else                            w_pred = w_psum[PRED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r2_v <= 1'b0;
        else if (w_adv) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_xp   <= r1_xp;
            r2_b    <= r1_b;
            r2_p    <= r1_p;
            r2_d    <= r1_d;
            r2_x    <= r1_x;
            r2_pd   <= r1_p * r1_d;
            r2_xx   <= r1_x * r1_x;
            r2_pred <= w_pred;
        end
    end

    // ---------------- stage 3: residuals, determinant ----------------
    logic             r3_v;
    logic [17:0]      r3_ua;
    logic [15:0]      r3_ub;
    logic             r3_sub;
    logic [VAR_W-1:0] r3_p, r3_d, r3_x;
    logic [DET_W-1:0] r3_det;
    t_meta            r3_m;
    logic signed [18:0] w_a, w_na;
    logic signed [16:0] w_nb;
    logic [DET_W:0]     w_det;
    logic               w_sing;

    assign w_a    = 19'(r2_xp) - 19'(r2_pred);
    assign w_na   = -w_a;
    assign w_nb   = -r2_b;
    assign w_det  = {1'b0, r2_pd} - {1'b0, r2_xx};
    assign w_sing = w_det[DET_W] || (w_det == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r3_v <= 1'b0;
        else if (w_adv) r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ua     <= w_a[18] ? w_na[17:0] : w_a[17:0];
            r3_ub     <= r2_b[16] ? w_nb[15:0] : r2_b[15:0];
            r3_sub    <= (w_a[18] == r2_b[16]);
            r3_p      <= r2_p;
            r3_d      <= r2_d;
            r3_x      <= r2_x;
            r3_det    <= w_det[DET_W-1:0];
            r3_m.zero <= w_sing;
            r3_m.sing <= w_sing;
            r3_m.pred <= r2_pred;
        end
    end

    // ---------------- stage 4: residual products ----------------
    logic             r4_v;
    logic [35:0]      r4_ua2;
    logic [31:0]      r4_ub2;
    logic [33:0]      r4_uab;
    logic             r4_sub;
    logic [VAR_W-1:0] r4_p, r4_d, r4_x;
    logic [DET_W-1:0] r4_det;
    t_meta            r4_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r4_v <= 1'b0;
        else if (w_adv) r4_v <= r3_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_ua2 <= r3_ua * r3_ua;
            r4_ub2 <= r3_ub * r3_ub;
            r4_uab <= r3_ua * r3_ub;
            r4_sub <= r3_sub;
            r4_p   <= r3_p;
            r4_d   <= r3_d;
            r4_x   <= r3_x;
            r4_det <= r3_det;
            r4_m   <= r3_m;
        end
    end

    // ---------------- stage 5: weighted partial products ----------------
    logic             r5_v;
    logic [41:0]      r5_m0, r5_m1;
    logic [55:0]      r5_m2;
    logic [40:0]      r5_c0, r5_c1;
    logic             r5_sub;
    logic [DET_W-1:0] r5_det;
    t_meta            r5_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r5_v <= 1'b0;
        else if (w_adv) r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_m0  <= r4_d * r4_ua2[17:0];
            r5_m1  <= r4_d * r4_ua2[35:18];
            r5_m2  <= r4_p * r4_ub2;
            r5_c0  <= r4_x * r4_uab[16:0];
            r5_c1  <= r4_x * r4_uab[33:17];
            r5_sub <= r4_sub;
            r5_det <= r4_det;
            r5_m   <= r4_m;
        end
    end

    // ---------------- stage 6: sum the quadratic form ----------------
    logic             r6_v;
    logic [70:0]      r6_np;
    logic [63:0]      r6_cr;
    logic             r6_sub;
    logic [DET_W-1:0] r6_det;
    t_meta            r6_m;
    logic [59:0]      w_dua;
    logic [57:0]      w_xab;

    assign w_dua = {r5_m1, 18'd0} + 60'(r5_m0);
    assign w_xab = {r5_c1, 17'd0} + 58'(r5_c0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r6_v <= 1'b0;
        else if (w_adv) r6_v <= r5_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_np  <= {1'b0, w_dua, 10'd0} + 71'(r5_m2);
            r6_cr  <= {w_xab, 6'd0};
            r6_sub <= r5_sub;
            r6_det <= r5_det;
            r6_m   <= r5_m;
        end
    end

    // ---------------- stage 7: cross term, range check ----------------
    logic [71:0] w_n;
    logic [73:0] w_n4;
    logic        w_cap;

    always_comb begin
        if (!r6_sub)                   w_n = 72'(r6_np) + 72'(r6_cr);
        else if (r6_np < 71'(r6_cr))   w_n = 72'd0;
        else                           w_n = 72'(r6_np - 71'(r6_cr));
    end

    assign w_n4  = {w_n, 2'b00};
    assign w_cap = w_n4 >= 74'({r6_det, 21'd0});

    // divider pipe, entry 0 is stage 7
    logic                 r_dv   [0:QV_W];
    logic [REM_W-1:0]     r_drem [0:QV_W];
    logic [QV_W-1:0]      r_dq   [0:QV_W];
    logic [DET_W-1:0]     r_ddet [0:QV_W];
    t_meta                r_dm   [0:QV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_dv[0] <= 1'b0;
        else if (w_adv) r_dv[0] <= r6_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_drem[0]    <= w_n4[REM_W-1:0];
            r_dq[0]      <= '0;
            r_ddet[0]    <= r6_det;
            r_dm[0].zero <= r6_m.zero || w_cap;
            r_dm[0].sing <= r6_m.sing;
            r_dm[0].pred <= r6_m.pred;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QV_W; j++) begin : g_div
        localparam int K = QV_W - 1 - j;
        logic [REM_W-1:0] w_sh;
        logic             w_ge;

        assign w_sh = REM_W'(r_ddet[j]) << K;
        assign w_ge = r_drem[j] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)   r_dv[j+1] <= 1'b0;
            else if (w_adv) r_dv[j+1] <= r_dv[j];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_drem[j+1] <= w_ge ? (r_drem[j] - w_sh) : r_drem[j];
                r_dq[j+1]   <= r_dq[j] | (QV_W'(w_ge) << K);
                r_ddet[j+1] <= r_ddet[j];
                r_dm[j+1]   <= r_dm[j];
            end
        end
    end

    // ---------------- Taylor series of exp(-w), w = q/32 in Q30 ----------------
    logic [QV_W-1:0] w_qv;
    t_meta           w_tmeta;

    assign w_qv         = r_dq[QV_W];
    assign w_tmeta.zero = r_dm[QV_W].zero || (w_qv >= Q_CAP);
    assign w_tmeta.sing = r_dm[QV_W].sing;
    assign w_tmeta.pred = r_dm[QV_W].pred;

    logic               w_sv   [1:N_TERMS];
    logic [30:0]        w_st   [1:N_TERMS];
    logic [29:0]        w_sw   [1:N_TERMS];
    logic signed [32:0] w_ss   [1:N_TERMS];
    t_meta              w_smt  [1:N_TERMS];

    logic               r_tcv  [1:N_TERMS];
    logic [30:0]        r_tct  [1:N_TERMS];
    logic [29:0]        r_tcw  [1:N_TERMS];
    logic signed [32:0] r_tcs  [1:N_TERMS];
    t_meta              r_tcm  [1:N_TERMS];

    for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
        localparam logic [31:0] M = recip(k);
        logic               r_av, r_bv;
        logic [60:0]        r_ap;
        logic [29:0]        r_aw, r_bw;
        logic signed [32:0] r_as, r_bs;
        t_meta              r_am, r_bm;
        logic [30:0]        r_bx, r_bq;
        logic [61:0]        w_ar;
        logic [30:0]        w_x;
        logic [62:0]        w_xm;
        logic [31:0]        w_r;
        logic [30:0]        w_q;

        if (k == 1) begin : g_seed
            assign w_sv[k]  = r_dv[QV_W];
            assign w_st[k]  = 31'd1 << 30;
            assign w_sw[k]  = {w_qv, 9'd0};
            assign w_ss[k]  = 33'sd1 <<< 30;
            assign w_smt[k] = w_tmeta;
        end else begin : g_chain
            assign w_sv[k]  = r_tcv[k-1];
            assign w_st[k]  = r_tct[k-1];
            assign w_sw[k]  = r_tcw[k-1];
            assign w_ss[k]  = r_tcs[k-1];
            assign w_smt[k] = r_tcm[k-1];
        end

        // round the product, then divide by k via reciprocal
        assign w_ar = 62'(r_ap) + (62'd1 << 29);
        assign w_x  = w_ar[60:30];
        assign w_xm = w_x * M;
        // fix the reciprocal estimate, which may be one low
        assign w_r  = 32'(r_bx) - 32'(r_bq * 31'(k));
        assign w_q  = (w_r >= 32'(k)) ? r_bq + 31'd1 : r_bq;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av     <= 1'b0;
                r_bv     <= 1'b0;
                r_tcv[k] <= 1'b0;
            end else if (w_adv) begin
                r_av     <= w_sv[k];
                r_bv     <= r_av;
                r_tcv[k] <= r_bv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ap     <= w_st[k] * w_sw[k];
                r_aw     <= w_sw[k];
                r_as     <= w_ss[k];
                r_am     <= w_smt[k];
                r_bx     <= w_x;
                r_bq     <= w_xm[62:32];
                r_bw     <= r_aw;
                r_bs     <= r_as;
                r_bm     <= r_am;
                r_tct[k] <= w_q;
                r_tcw[k] <= r_bw;
                r_tcs[k] <= (k % 2 == 1) ? r_bs - 33'(w_q) : r_bs + 33'(w_q);
                r_tcm[k] <= r_bm;
            end
        end
    end

    // ---------------- raise to the 16th power ----------------
    logic        r_qv [0:N_SQ-1];
    logic [61:0] r_qp [0:N_SQ-1];
    t_meta       r_qm [0:N_SQ-1];
    logic [30:0] w_qe [0:N_SQ];

    assign w_qe[0] = r_tcs[N_TERMS][32] ? 31'd0 : r_tcs[N_TERMS][30:0];

    for (genvar i = 0; i < N_SQ; i++) begin : g_sq
        logic [62:0] w_rnd;

        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n)   r_qv[i] <= 1'b0;
                else if (w_adv) r_qv[i] <= r_tcv[N_TERMS];
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) r_qm[i] <= r_tcm[N_TERMS];
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n)   r_qv[i] <= 1'b0;
                else if (w_adv) r_qv[i] <= r_qv[i-1];
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) r_qm[i] <= r_qm[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) r_qp[i] <= w_qe[i] * w_qe[i];
        end

        assign w_rnd     = 63'(r_qp[i]) + (63'd1 << 29);
        assign w_qe[i+1] = w_rnd[60:30];
    end

    // ---------------- output register ----------------
    logic                     r_out_v;
    logic [LIK_W-1:0]         r_out_lik;
    logic signed [PRED_W-1:0] r_out_pred;
    logic                     r_out_excl, r_out_sing;
    logic [31:0]              w_lr;
    logic [LIK_W-1:0]         w_lik;

    assign w_lr  = 32'(w_qe[N_SQ]) + 32'd8192;
    assign w_lik = r_qm[N_SQ-1].zero ? '0 : w_lr[30:14];
    assign w_adv = !r_out_v || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_out_v <= 1'b0;
        else if (w_adv) r_out_v <= r_qv[N_SQ-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_lik  <= w_lik;
            r_out_pred <= r_qm[N_SQ-1].pred;
            r_out_excl <= w_lik < r_thr;
            r_out_sing <= r_qm[N_SQ-1].sing;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'd0, r_out_sing, r_out_excl, r_out_pred, r_out_lik};

endmodule

// File: rtl/tlg_checker.sv
// Port-level checks of the track likelihood gate, bound to the top level.
module tlg_checker
    import tlg_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] i_m_tdata,
    input logic             i_pready
);

    // hold a result that is not taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // drop the likelihood on a singular covariance
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[36] |-> i_m_tdata[16:0] == '0)
        else $error("singular track with nonzero likelihood");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[16:0] <= LIK_ONE && i_m_tdata[39:37] == '0)
        else $error("likelihood out of range");

    // no result right after a reset cycle
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    a_ready: assert property (@(posedge i_clk) i_pready)
        else $error("config port not ready");

endmodule

bind track_likelihood_gate tlg_checker u_tlg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_pready   (pready)
);
